// ----- sv/bfc_pkg.sv -----
// Shared types, widths and defaults for the block FIR convolver.
package bfc_pkg;

  localparam int MAX_TAPS_DEF = 256;
  localparam int BLOCK_DEF    = 32;
  localparam int QUEUE_DEPTH  = 4;

  localparam int ACTION_W    = 2;
  localparam int SAMPLE_W    = 24;
  localparam int TAP_W       = 18;
  localparam int TAP_IDX_W   = 8;
  localparam int TAP_COUNT_W = 9;
  localparam int POS_W       = 5;
  localparam int PROD_W      = SAMPLE_W + TAP_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_TAP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_TAP,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e                        kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [TAP_IDX_W-1:0] tap_index;
    logic signed [TAP_W-1:0]     tap_value;
  } cmd_t;

  typedef struct packed {
    logic ready;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } back_state_e;

endpackage

// ----- sv/bfc_front.sv -----
// Front end: accepts input words, decodes the action and forwards commands.
module bfc_front #(
  parameter int MAX_TAPS = bfc_pkg::MAX_TAPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [bfc_pkg::ACTION_W-1:0]           action_i,
  input  logic signed [bfc_pkg::SAMPLE_W-1:0]    sample_in_i,
  input  logic [bfc_pkg::TAP_IDX_W-1:0]          tap_index_i,
  input  logic signed [bfc_pkg::TAP_W-1:0]       tap_value_i,
  input  bfc_pkg::back_status_t                  status_i,
  output logic                                   push_o,
  output bfc_pkg::cmd_t                          push_data_o,
  input  logic                                   full_i
);
  import bfc_pkg::*;

  logic cmd_valid_q, cmd_valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  logic keep;
  cmd_t decoded;

  assign in_stall_o = !status_i.ready || (cmd_valid_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = cmd_valid_q && !full_i;
  assign push_data_o = cmd_q;

  // Unused codes and tap writes beyond the store are dropped here.
  always_comb begin
    decoded.sample    = sample_in_i;
    decoded.tap_index = tap_index_i;
    decoded.tap_value = tap_value_i;
    decoded.kind      = CMD_PUSH;
    keep              = 1'b0;
    unique case (action_e'(action_i))
      ACT_PUSH: begin
        decoded.kind = CMD_PUSH;
        keep         = 1'b1;
      end
      ACT_TAP: begin
        decoded.kind = CMD_TAP;
        keep         = (32'(tap_index_i) < 32'(MAX_TAPS));
      end
      ACT_CLEAR: begin
        decoded.kind = CMD_CLEAR;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    cmd_d       = cmd_q;
    if (push_o) begin
      cmd_valid_d = 1'b0;
    end
    if (accept && keep) begin
      cmd_valid_d = 1'b1;
      cmd_d       = decoded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ----- sv/bfc_queue.sv -----
// Small command queue between the front end and the compute engine.
module bfc_queue #(
  parameter int DEPTH = bfc_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bfc_pkg::cmd_t  push_data_i,
  output logic           full_o,
  output logic           valid_o,
  output bfc_pkg::cmd_t  data_o,
  input  logic           pop_i
);
  import bfc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/bfc_back.sv -----
// Compute engine: history and tap stores, one multiply-accumulate unit, output register.
module bfc_back #(
  parameter int MAX_TAPS = bfc_pkg::MAX_TAPS_DEF,
  parameter int BLOCK    = bfc_pkg::BLOCK_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  input  bfc_pkg::cmd_t                         cmd_i,
  output logic                                  cmd_pop_o,
  input  logic [bfc_pkg::TAP_COUNT_W-1:0]       tap_count_i,
  output bfc_pkg::back_status_t                 status_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bfc_pkg::SAMPLE_W-1:0]   sample_out_o,
  output logic [bfc_pkg::POS_W-1:0]             position_in_block_o,
  output logic                                  last_of_block_o
);
  import bfc_pkg::*;

  localparam int HIST  = MAX_TAPS + BLOCK;
  localparam int HAW   = $clog2(HIST);
  localparam int TAW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int UW    = $clog2(MAX_TAPS + 1);
  localparam int TOTW  = $clog2(HIST + 1);
  localparam int RW    = TOTW + 1;
  localparam int NW    = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int ACC_W = PROD_W + UW;

  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] Y_MIN = -ACC_W'(8388608);

  // Stores
  logic signed [SAMPLE_W-1:0] hist_mem [HIST];
  logic signed [TAP_W-1:0]    tap_mem  [MAX_TAPS];

  back_state_e state_q, state_d;

  logic [TAW-1:0]  clr_cnt_q;
  logic [HAW-1:0]  wp_q, wp_inc;
  logic [TOTW-1:0] total_q, total_new;
  logic [NW-1:0]   pend_q, n_q;
  logic [UW-1:0]   used_q, used_d, k_q, k_next;
  logic [HAW-1:0]  base_q, pos_q, base0;
  logic [HAW:0]    base_sum;
  logic [RW-1:0]   tn_q, rel_q;

  logic                       p1_q, p1_zero_q, p2_q;
  logic signed [SAMPLE_W-1:0] hist_rd_q;
  logic signed [TAP_W-1:0]    tap_rd_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q, rnd, y;
  logic signed [SAMPLE_W-1:0] y_sat;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic [POS_W-1:0]           out_pos_q;
  logic                       out_last_q;

  logic                       hist_we, tap_we, issue, load_out, block_done, n_last;
  logic [TAW-1:0]             tap_wa;
  logic signed [TAP_W-1:0]    tap_wd;

  assign status_o.ready      = (state_q != ST_INIT);
  assign out_valid_o         = out_valid_q;
  assign sample_out_o        = out_sample_q;
  assign position_in_block_o = out_pos_q;
  assign last_of_block_o     = out_last_q;

  // Address and count arithmetic
  assign wp_inc    = (wp_q == HAW'(HIST - 1)) ? '0 : wp_q + HAW'(1);
  assign total_new = (total_q == TOTW'(HIST)) ? total_q : total_q + TOTW'(1);
  assign base_sum  = {1'b0, wp_q} + (HAW + 1)'(HIST - BLOCK + 1);
  assign base0     = (base_sum >= (HAW + 1)'(HIST)) ? HAW'(base_sum - (HAW + 1)'(HIST))
                                                    : HAW'(base_sum);
  assign used_d    = (32'(tap_count_i) > 32'(MAX_TAPS)) ? UW'(MAX_TAPS) : UW'(tap_count_i);
  assign k_next    = k_q + UW'(1);
  assign n_last    = (n_q == NW'(BLOCK - 1));

  // Round half up, then saturate to the sample range.
  assign rnd = acc_q + ACC_W'(32768);
  assign y   = rnd >>> 16;
  always_comb begin
    if (y > Y_MAX) begin
      y_sat = SAMPLE_W'(Y_MAX);
    end else if (y < Y_MIN) begin
      y_sat = SAMPLE_W'(Y_MIN);
    end else begin
      y_sat = SAMPLE_W'(y);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (clr_cnt_q == TAW'(MAX_TAPS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (block_done) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = (used_q == '0) ? ST_DRAIN : ST_MAC;
      end
      ST_MAC: begin
        if (k_next == used_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_q && !p2_q) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out) state_d = n_last ? ST_IDLE : ST_SETUP;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // State outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    hist_we    = 1'b0;
    tap_we     = 1'b0;
    tap_wa     = TAW'(cmd_i.tap_index);
    tap_wd     = cmd_i.tap_value;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        tap_we = 1'b1;
        tap_wa = clr_cnt_q;
        tap_wd = '0;
      end
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        hist_we   = cmd_valid_i && (cmd_i.kind == CMD_PUSH);
        tap_we    = cmd_valid_i && (cmd_i.kind == CMD_TAP);
      end
      ST_MAC: begin
        issue = 1'b1;
      end
      ST_EMIT: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  assign block_done = hist_we && (pend_q == NW'(BLOCK - 1));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_cnt_q   <= '0;
      wp_q        <= '0;
      total_q     <= '0;
      pend_q      <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_q    <= issue;
      p2_q    <= p1_q;
      if (state_q == ST_INIT) begin
        clr_cnt_q <= clr_cnt_q + TAW'(1);
      end
      if (hist_we) begin
        wp_q    <= wp_inc;
        total_q <= total_new;
        pend_q  <= block_done ? '0 : pend_q + NW'(1);
      end
      if (cmd_pop_o && (cmd_i.kind == CMD_CLEAR)) begin
        wp_q    <= '0;
        total_q <= '0;
        pend_q  <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (block_done) begin
      used_q <= used_d;
      n_q    <= '0;
      base_q <= base0;
      tn_q   <= RW'(total_new) - RW'(BLOCK);
    end
    if (state_q == ST_SETUP) begin
      pos_q <= base_q;
      rel_q <= tn_q;
      k_q   <= '0;
      acc_q <= '0;
    end
    if (issue) begin
      k_q   <= k_next;
      pos_q <= (pos_q == '0) ? HAW'(HIST - 1) : pos_q - HAW'(1);
      rel_q <= rel_q - RW'(1);
    end
    p1_zero_q <= rel_q[RW-1];
    // Samples from before the start of the stream count as zero.
    if (p1_zero_q) begin
      prod_q <= '0;
    end else begin
      prod_q <= hist_rd_q * tap_rd_q;
    end
    if (p2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (load_out) begin
      out_sample_q <= y_sat;
      out_pos_q    <= POS_W'(n_q);
      out_last_q   <= n_last;
      if (!n_last) begin
        n_q    <= n_q + NW'(1);
        base_q <= (base_q == HAW'(HIST - 1)) ? '0 : base_q + HAW'(1);
        tn_q   <= tn_q + RW'(1);
      end
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[wp_q] <= cmd_i.sample;
    end
    hist_rd_q <= hist_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[tap_wa] <= tap_wd;
    end
    tap_rd_q <= tap_mem[k_q[TAW-1:0]];
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(out_valid_q && out_stall_i))
    else $error("output register reloaded while its word is stalled");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!p1_q && !p2_q))
    else $error("result taken before the accumulator pipeline drained");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (k_q < used_q))
    else $error("tap index issued beyond the taps in use");

  a_no_write_during_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> (!p1_q && !p2_q))
    else $error("history written while a block is being computed");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_pos_q == POS_W'(BLOCK - 1)))
    else $error("last word of a block carries the wrong position");
`endif

endmodule

// ----- sv/block_fir_convolver.sv -----
// Top level of the block FIR convolver: front end, command queue and compute engine.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  action_i, sample_in_i, tap_index_i, tap_value_i
//   out      output     out_valid_o / out_stall_i
//                                                sample_out_o, position_in_block_o,
//                                                last_of_block_o
//   cfg      input      cfg_we_i                 cfg_wdata_i (tap_count)
//
// Tap writes, clears and pushes that do not complete a block are taken by the engine
// while it is idle. The push that completes a block starts BLOCK outputs. Each output
// takes one term per tap in use (tap_count, clamped to MAX_TAPS) on the single
// multiply-accumulate unit, and none when no taps are in use. The tap store and the history
// store each have one read port, which feed that unit one term per cycle.
// After reset the engine zeroes all MAX_TAPS entries of the tap store, one entry a
// cycle; in_stall_o stays high during that pass and configuration writes are
// taken as usual. The command queue lets the front end keep accepting words while
// the engine computes, and the output register lets the engine move on while a
// finished word waits on out_stall_i.
module block_fir_convolver #(
  parameter int MAX_TAPS = bfc_pkg::MAX_TAPS_DEF,
  parameter int BLOCK    = bfc_pkg::BLOCK_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [bfc_pkg::ACTION_W-1:0]          action_i,
  input  logic signed [bfc_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  logic [bfc_pkg::TAP_IDX_W-1:0]         tap_index_i,
  input  logic signed [bfc_pkg::TAP_W-1:0]      tap_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bfc_pkg::SAMPLE_W-1:0]   sample_out_o,
  output logic [bfc_pkg::POS_W-1:0]             position_in_block_o,
  output logic                                  last_of_block_o,
  input  logic                                  cfg_we_i,
  input  logic [bfc_pkg::TAP_COUNT_W-1:0]       cfg_wdata_i
);
  import bfc_pkg::*;

  // The tap count register; the engine clamps it to MAX_TAPS when a block starts.
  logic [TAP_COUNT_W-1:0] tap_count_q;

  back_status_t status;
  logic         push, full, q_valid, pop;
  cmd_t         push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_W'(1);
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  // Decodes actions and drops the ones that have no effect.
  bfc_front #(
    .MAX_TAPS (MAX_TAPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_in_i (sample_in_i),
    .tap_index_i (tap_index_i),
    .tap_value_i (tap_value_i),
    .status_i    (status),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  bfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (pop)
  );

  // Owns both stores and runs the convolution one term per cycle.
  bfc_back #(
    .MAX_TAPS (MAX_TAPS),
    .BLOCK    (BLOCK)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_valid_i         (q_valid),
    .cmd_i               (q_data),
    .cmd_pop_o           (pop),
    .tap_count_i         (tap_count_q),
    .status_o            (status),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .sample_out_o        (sample_out_o),
    .position_in_block_o (position_in_block_o),
    .last_of_block_o     (last_of_block_o)
  );

endmodule
